/* rtl/lzwe_pkg.sv */
// ----------------------------------------------------------------------------
// LZW encoder package
// Shared types and constants for the fixed-width-code LZW encoder.
// ----------------------------------------------------------------------------
package lzwe_pkg;

	// Kind of a queued input item.
	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_END  = 1'b1
	} cmd_kind_t;

	// One classified item passed from the front end to the engine.
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	// First code that the dictionary hands out; codes below are single bytes.
	localparam int FIRST_FREE = 256;

	// Width of the stream tag kept in every hash slot.
	localparam int EPOCH_BITS = 16;

endpackage

/* rtl/lzwe_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lzwe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/lzwe_front.sv */
// ----------------------------------------------------------------------------
// LZW encoder front end
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lzwe_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,   // [7:0] data_byte
	input  logic            s_tlast,   // end_of_stream
	output logic            cmd_valid,
	output lzwe_pkg::cmd_t  cmd,
	input  logic            cmd_pop
);

	lzwe_pkg::cmd_t queue_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	lzwe_pkg::cmd_t incoming;

	always_comb begin
		incoming.kind = s_tlast ? lzwe_pkg::CMD_END : lzwe_pkg::CMD_BYTE;
		// The byte carries no meaning on an end item.
		incoming.data = s_tlast ? 8'd0 : s_tdata;
	end

	assign s_tready  = (count_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/lzwe_engine.sv */
// ----------------------------------------------------------------------------
// LZW encoder engine
// Runs the dictionary lookup and insert over a hash table held in RAM.
// ----------------------------------------------------------------------------
module lzwe_engine #(
	parameter int DICT_LIMIT = 65535,
	parameter int CODE_BITS  = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  lzwe_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [15:0]    m_tdata,   // [15:0] code
	output logic           m_tlast    // final_code
);

	localparam int KEY_W  = CODE_BITS + 8;
	localparam int SLOT_W = CODE_BITS + 1;
	localparam int SLOT_N = 2 ** SLOT_W;
	localparam int WORD_W = lzwe_pkg::EPOCH_BITS + KEY_W + CODE_BITS;
	localparam int CAP    = (DICT_LIMIT < 2 ** CODE_BITS) ? DICT_LIMIT : 2 ** CODE_BITS;
	localparam logic [SLOT_W-1:0] CAP_V   = SLOT_W'(CAP);
	localparam logic [SLOT_W-1:0] FREE0_V = SLOT_W'(lzwe_pkg::FIRST_FREE);
	localparam logic [lzwe_pkg::EPOCH_BITS-1:0] EPOCH_MAX = '1;
	localparam logic [lzwe_pkg::EPOCH_BITS-1:0] EPOCH_ONE = lzwe_pkg::EPOCH_BITS'(1);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_CMP   = 3'b100
	} state_t;

	state_t                        state_q;
	logic [SLOT_W-1:0]             clr_q;
	logic [SLOT_W-1:0]             probe_q;
	logic [lzwe_pkg::EPOCH_BITS-1:0] epoch_q;
	logic [SLOT_W-1:0]             next_free_q;
	logic [CODE_BITS-1:0]          prefix_q;
	logic                          present_q;
	logic [7:0]                    byte_q;
	logic                          out_valid_q;
	logic [15:0]                   out_code_q;
	logic                          out_last_q;

	logic                          we;
	logic [SLOT_W-1:0]             waddr;
	logic [WORD_W-1:0]             wdata;
	logic [SLOT_W-1:0]             raddr;
	logic [WORD_W-1:0]             rdata;
	logic [KEY_W-1:0]              idle_key;
	logic [KEY_W-1:0]              cur_key;
	logic [SLOT_W-1:0]             idle_hash;
	logic [lzwe_pkg::EPOCH_BITS-1:0] rd_epoch;
	logic [KEY_W-1:0]              rd_key;
	logic [CODE_BITS-1:0]          rd_code;
	logic                          slot_live;
	logic                          slot_hit;

	assign idle_key  = {prefix_q, cmd.data};
	assign cur_key   = {prefix_q, byte_q};
	assign idle_hash = idle_key[SLOT_W-1:0]
		^ {idle_key[KEY_W-1:SLOT_W], {(SLOT_W-7){1'b0}}};

	assign rd_epoch  = rdata[WORD_W-1 -: lzwe_pkg::EPOCH_BITS];
	assign rd_key    = rdata[KEY_W+CODE_BITS-1:CODE_BITS];
	assign rd_code   = rdata[CODE_BITS-1:0];
	assign slot_live = (rd_epoch == epoch_q);
	assign slot_hit  = slot_live && (rd_key == cur_key);

	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid && !out_valid_q;

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		raddr = probe_q + SLOT_W'(1);
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_IDLE: begin
				raddr = idle_hash;
			end
			S_CMP: begin
				waddr = probe_q;
				wdata = {epoch_q, cur_key, next_free_q[CODE_BITS-1:0]};
				we    = !slot_live && (next_free_q < CAP_V);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	lzwe_ram #(
		.WIDTH (WORD_W),
		.DEPTH (SLOT_N)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			byte_q <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			probe_q     <= '0;
			epoch_q     <= EPOCH_ONE;
			next_free_q <= FREE0_V;
			prefix_q    <= '0;
			present_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_code_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_pop) begin
						if (cmd.kind == lzwe_pkg::CMD_END) begin
							out_valid_q <= 1'b1;
							out_last_q  <= 1'b1;
							out_code_q  <= present_q ? 16'(prefix_q) : 16'd0;
							present_q   <= 1'b0;
							prefix_q    <= '0;
							next_free_q <= FREE0_V;
							if (epoch_q == EPOCH_MAX) begin
								epoch_q <= EPOCH_ONE;
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end else begin
								epoch_q <= epoch_q + EPOCH_ONE;
							end
						end else if (!present_q) begin
							prefix_q  <= CODE_BITS'(cmd.data);
							present_q <= 1'b1;
						end else begin
							probe_q <= idle_hash;
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					if (slot_hit) begin
						prefix_q <= rd_code;
						state_q  <= S_IDLE;
					end else if (slot_live) begin
						probe_q <= probe_q + SLOT_W'(1);
					end else begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b0;
						out_code_q  <= 16'(prefix_q);
						prefix_q    <= CODE_BITS'(byte_q);
						if (next_free_q < CAP_V) begin
							next_free_q <= next_free_q + SLOT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_code_q;
	assign m_tlast  = out_last_q;

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= CAP_V)
		else $error("dictionary grew past its limit");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP && we) |=> next_free_q == $past(next_free_q) + SLOT_W'(1))
		else $error("insert did not advance the free code");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.kind == lzwe_pkg::CMD_END) |=>
			(!present_q && next_free_q == FREE0_V && out_valid_q && out_last_q))
		else $error("end item did not flush and reset the stream");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !out_valid_q && state_q == S_IDLE)
		else $error("item taken while the engine was busy");

endmodule

/* rtl/lzw_encoder_16bit_codes.sv */
// ----------------------------------------------------------------------------
// LZW encoder with fixed-width codes
// Compresses a byte stream into CODE_BITS-wide dictionary codes.
// ----------------------------------------------------------------------------
// Each byte item is looked up as a (prefix code, byte) pair; a hit grows the
// prefix, a miss emits the prefix code, adds the pair as the next free code
// while the dictionary holds fewer than DICT_LIMIT (capped at 2^CODE_BITS)
// entries, and restarts from the byte. An item with tlast set flushes the
// pending prefix (code 0 for an empty stream) with tlast set on the output,
// then starts a fresh dictionary. The first byte of a stream only loads the
// prefix; every other byte issues the hash-table read and then probes one
// slot after another until it finds its pair or an empty slot. The probe
// loop runs over the single hash-table RAM. A two-entry queue lets input
// items be accepted while the engine works, and the output register holds
// a result until taken; the engine starts an item only once the output
// register is empty. The table is tagged with a stream number so that an
// end item clears it at once; after reset, and again after every 65535
// streams when the tag wraps, the engine sweeps all 2^(CODE_BITS+1) slots,
// one per cycle (131072 slots with 16-bit codes), before it takes the next
// item.
// ----------------------------------------------------------------------------
module lzw_encoder_16bit_codes #(
	parameter int DICT_LIMIT = 65535,
	parameter int CODE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream of bytes.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_stream
	// Output stream of codes.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code
	output logic        m_tlast    // final_code
);

	logic           cmd_valid;
	logic           cmd_pop;
	lzwe_pkg::cmd_t cmd;

	// The front end classifies items into byte and end commands.
	lzwe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// The engine owns the dictionary and the output register.
	lzwe_engine #(
		.DICT_LIMIT (DICT_LIMIT),
		.CODE_BITS  (CODE_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
